// ===== rtl/core/ctf_pkg.sv =====
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared widths, defaults and the arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
package ctf_pkg;

  localparam int SENSORS_DEF       = 2;
  localparam int CALIB_SAMPLES_DEF = 100;
  localparam int CORDIC_STEPS_DEF  = 16;

  localparam int CNT_W  = 7;   // calibration attempt counter
  localparam int SUM_W  = 24;  // calibration sums
  localparam int AX_W   = 16;  // raw sample fields
  localparam int ANG_W  = 24;  // output angles, 1/256 degree
  localparam int CIN_W  = 17;  // CORDIC operands
  localparam int FRAC_W = 24;  // CORDIC operand scaling
  localparam int CXY_W  = 45;  // CORDIC x/y datapath
  localparam int CZ_W   = 26;  // CORDIC angle, 1/65536 degree
  localparam int MA_W   = 17;  // serial multiplier, unsigned operand
  localparam int MB_W   = 48;  // serial multiplier, signed operand
  localparam int MP_W   = 65;  // serial multiplier, product
  localparam int SQ_W   = 32;  // radicand

  typedef enum logic [1:0] {
    ST_CAL_TAKEN = 2'd0,
    ST_CAL_DONE  = 2'd1,
    ST_ANGLES    = 2'd2,
    ST_FAIL      = 2'd3
  } status_t;

  function automatic logic signed [CZ_W-1:0] atan_entry(input logic [4:0] i);
    logic signed [CZ_W-1:0] v;
    case (i)
      5'd0:  v = CZ_W'(2949120);
      5'd1:  v = CZ_W'(1740967);
      5'd2:  v = CZ_W'(919879);
      5'd3:  v = CZ_W'(466945);
      5'd4:  v = CZ_W'(234379);
      5'd5:  v = CZ_W'(117304);
      5'd6:  v = CZ_W'(58666);
      5'd7:  v = CZ_W'(29335);
      5'd8:  v = CZ_W'(14668);
      5'd9:  v = CZ_W'(7334);
      5'd10: v = CZ_W'(3667);
      5'd11: v = CZ_W'(1833);
      5'd12: v = CZ_W'(917);
      5'd13: v = CZ_W'(458);
      5'd14: v = CZ_W'(229);
      5'd15: v = CZ_W'(115);
      5'd16: v = CZ_W'(57);
      5'd17: v = CZ_W'(29);
      5'd18: v = CZ_W'(14);
      5'd19: v = CZ_W'(7);
      5'd20: v = CZ_W'(4);
      5'd21: v = CZ_W'(2);
      5'd22: v = CZ_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/ctf_div.sv =====
// ----------------------------------------------------------------------------
// ctf_div
// Bit-serial signed division by a constant, truncating toward zero.
// ----------------------------------------------------------------------------
module ctf_div import ctf_pkg::*; #(
  parameter int DIVISOR = CALIB_SAMPLES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  output logic                    done,
  output logic signed [SUM_W-1:0] quot
);

  localparam int CW = $clog2(SUM_W);
  localparam logic [CNT_W:0] DIV_C = (CNT_W+1)'(DIVISOR);

  logic          busy;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [SUM_W-1:0] num, q;
  logic [CNT_W:0]   rem, rem_sh, rem_next;
  logic             qbit;

  always_comb begin
    rem_sh = {rem[CNT_W-1:0], num[SUM_W-1]};
    qbit   = (rem_sh >= DIV_C);
    rem_next = qbit ? rem_sh - DIV_C : rem_sh;
  end

  assign quot = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= dividend[SUM_W-1];
        num  <= dividend[SUM_W-1] ? -dividend : dividend;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        num <= num << 1;
        q   <= {q[SUM_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(SUM_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/ctf_sqrt.sv =====
// ----------------------------------------------------------------------------
// ctf_sqrt
// Floor integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ctf_sqrt import ctf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [SQ_W/2-1:0] root
);

  localparam int CW = $clog2(SQ_W/2);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [SQ_W-1:0] v, r, bitm;
  logic [SQ_W:0]   trial;

  assign trial = {1'b0, r} + {1'b0, bitm};
  assign root  = r[SQ_W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        v    <= radicand;
        r    <= '0;
        bitm <= SQ_W'(1) << (SQ_W-2);
      end else if (busy) begin
        if ({1'b0, v} >= trial) begin
          v <= v - trial[SQ_W-1:0];
          r <= (r >> 1) + bitm;
        end else begin
          r <= r >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(SQ_W/2-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/ctf_cordic.sv =====
// ----------------------------------------------------------------------------
// ctf_cordic
// Vectoring CORDIC atan2, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ctf_cordic import ctf_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [CIN_W-1:0] y_in,
  input  logic signed [CIN_W-1:0] x_in,
  output logic                    done,
  output logic signed [CZ_W-1:0]  z_out
);

  localparam int PAD = CXY_W - CIN_W - FRAC_W;
  localparam logic signed [CZ_W-1:0] Z90 = CZ_W'(90 * 65536);

  logic                    busy, zero;
  logic [4:0]              idx;
  logic signed [CXY_W-1:0] xr, yr, xs, ys, dx, dy;
  logic signed [CZ_W-1:0]  zr;

  assign xs = $signed({{PAD{x_in[CIN_W-1]}}, x_in, {FRAC_W{1'b0}}});
  assign ys = $signed({{PAD{y_in[CIN_W-1]}}, y_in, {FRAC_W{1'b0}}});
  assign dx = yr >>> idx;
  assign dy = xr >>> idx;
  // both operands zero: angle is zero
  assign z_out = zero ? '0 : zr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
        zero <= (x_in == 0) && (y_in == 0);
        if (x_in < 0) begin
          if (y_in >= 0) begin
            zr <= Z90;
            xr <= ys;
            yr <= -xs;
          end else begin
            zr <= -Z90;
            xr <= -ys;
            yr <= xs;
          end
        end else begin
          zr <= '0;
          xr <= xs;
          yr <= ys;
        end
      end else if (busy) begin
        if (!yr[CXY_W-1]) begin
          xr <= xr + dx;
          yr <= yr - dy;
          zr <= zr + atan_entry(idx);
        end else begin
          xr <= xr - dx;
          yr <= yr + dy;
          zr <= zr - atan_entry(idx);
        end
        idx <= idx + 1'b1;
        if (idx == 5'(STEPS-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/ctf_mul.sv =====
// ----------------------------------------------------------------------------
// ctf_mul
// Shift-and-add multiplier, one bit of the unsigned operand per cycle.
// ----------------------------------------------------------------------------
module ctf_mul import ctf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [MA_W-1:0]        a,
  input  logic signed [MB_W-1:0] b,
  output logic                   done,
  output logic signed [MP_W-1:0] p
);

  localparam int CW = $clog2(MA_W);

  logic                   busy;
  logic [CW-1:0]          cnt;
  logic [MA_W-1:0]        ar;
  logic signed [MP_W-1:0] br;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        ar   <= a;
        br   <= MP_W'(b);
        p    <= '0;
      end else if (busy) begin
        if (ar[0]) begin
          p <= p + br;
        end
        br  <= br <<< 1;
        ar  <= ar >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(MA_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/imu_tilt_complementary_filter.sv =====
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter
// Per-sensor accelerometer calibration and pitch/roll complementary filter.
// ----------------------------------------------------------------------------
//  channel  | signals                  | content
//  ---------+--------------------------+---------------------------------------
//  s_axis   | s_tvalid/s_tready/...    | one sample transaction (calib/measure)
//  m_axis   | m_tvalid/m_tready/...    | one result transaction per sample
//  apb      | psel/penable/paddr/...   | blend_alpha 0x0, gyro_step_gain 0x4,
//           |                          | gravity_lsb 0x8
//
// One sample at a time. A calibration attempt that closes a round runs the
// bit-serial divider once per axis. A measurement is dominated by two
// CORDIC passes and six 17-bit serial multiplies. Reset is synchronous and
// clears the control, configuration and per-sensor state; no clearing pass
// follows. A stalled result holds in the output register; the next sample
// is taken meanwhile and waits for the slot at its end.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter import ctf_pkg::*; #(
  parameter int SENSORS       = SENSORS_DEF,
  parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF,
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // accel_x, accel_y, accel_z, gyro_x, gyro_y
  input  logic [2:0]  s_tuser,  // req_type, sensor_id, read_ok
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // pitch_deg, roll_deg
  output logic [2:0]  m_tuser,  // out_sensor, status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SIDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_GAIN  = 2'd1;
  localparam logic [1:0] REG_GRAV  = 2'd2;
  localparam logic signed [MP_W:0] SAT_HI = (MP_W+1)'(8388607);
  localparam logic signed [MP_W:0] SAT_LO = ~SAT_HI;
  localparam logic signed [MP_W:0] ROUND  = (MP_W+1)'(64'd1 << 30);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CAL_START, S_CAL_WAIT, S_SQ1, S_SQ2, S_SQ3,
    S_PWAIT, S_CROLL, S_RWAIT, S_RG, S_RGW, S_M1W, S_M2W, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [15:0] blend_alpha, gyro_step_gain;
  logic [14:0] gravity_lsb;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_ALPHA: prdata = {16'b0, blend_alpha};
      REG_GAIN:  prdata = {16'b0, gyro_step_gain};
      REG_GRAV:  prdata = {17'b0, gravity_lsb};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_alpha    <= 16'd32113;
      gyro_step_gain <= 16'd6404;
      gravity_lsb    <= 15'd16384;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ALPHA: blend_alpha    <= pwdata[15:0];
        REG_GAIN:  gyro_step_gain <= pwdata[15:0];
        REG_GRAV:  gravity_lsb    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // per-sensor state
  logic signed [SUM_W-1:0] calib_sum_x [SENSORS];
  logic signed [SUM_W-1:0] calib_sum_y [SENSORS];
  logic signed [SUM_W-1:0] calib_sum_z [SENSORS];
  logic [CNT_W-1:0]        calib_count [SENSORS];
  logic signed [AX_W-1:0]  offset_x [SENSORS];
  logic signed [AX_W-1:0]  offset_y [SENSORS];
  logic signed [AX_W-1:0]  offset_z [SENSORS];
  logic signed [ANG_W-1:0] pitch_store [SENSORS];
  logic signed [ANG_W-1:0] roll_store [SENSORS];

  // held sample
  logic it_type, it_sid, it_ok;
  logic signed [AX_W-1:0] it_ax, it_ay, it_az, it_gx, it_gy;
  logic [SIDX_W-1:0] sidx;
  logic              s_ok;

  assign sidx = SIDX_W'(it_sid);
  assign s_ok = int'(it_sid) < SENSORS;

  // working registers
  logic signed [AX_W-1:0]  cx, cy, cz;
  logic signed [SQ_W-1:0]  sq_y, sq_z;
  logic signed [CZ_W-1:0]  acc_p, acc_r;
  logic signed [MP_W-1:0]  m1;
  logic [1:0]              axis;
  logic                    ang, fsq, fcp;
  status_t                 res_status;
  logic signed [ANG_W-1:0] res_p, res_r;

  // calibration arithmetic
  logic [CNT_W-1:0]        cnt_new;
  logic signed [SUM_W-1:0] sum_x_n, sum_y_n, sum_z_n;

  always_comb begin
    cnt_new = calib_count[sidx] + 1'b1;
    sum_x_n = calib_sum_x[sidx] + SUM_W'(it_ax);
    sum_y_n = calib_sum_y[sidx] + SUM_W'(it_ay);
    sum_z_n = calib_sum_z[sidx] + SUM_W'(it_az);
  end

  // units
  logic                    div_start, div_done;
  logic signed [SUM_W-1:0] div_din, div_q;
  logic                    sqrt_start, sqrt_done;
  logic [SQ_W-1:0]         sqrt_din;
  logic [SQ_W/2-1:0]       sqrt_root;
  logic                    cord_start, cord_done;
  logic signed [CIN_W-1:0] cord_y, cord_x;
  logic signed [CZ_W-1:0]  cord_z;
  logic                    mul_start, mul_done;
  logic [MA_W-1:0]         mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  mul_p;

  ctf_div #(.DIVISOR(CALIB_SAMPLES)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_din),
    .done(div_done), .quot(div_q)
  );

  ctf_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(sqrt_din),
    .done(sqrt_done), .root(sqrt_root)
  );

  ctf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cord_start), .y_in(cord_y), .x_in(cord_x),
    .done(cord_done), .z_out(cord_z)
  );

  ctf_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  // blend arithmetic for the angle in progress
  logic [MA_W-1:0]         alpha_c, beta_c;
  logic signed [ANG_W-1:0] store_sel;
  logic signed [AX_W-1:0]  rate_sel;
  logic signed [CZ_W-1:0]  acc_sel;
  logic signed [MP_W:0]    vsum, vsh;
  logic signed [ANG_W-1:0] ang_new;

  always_comb begin
    alpha_c   = (blend_alpha > 16'd32768) ? MA_W'(32768) : MA_W'(blend_alpha);
    beta_c    = MA_W'(32768) - alpha_c;
    store_sel = ang ? roll_store[sidx] : pitch_store[sidx];
    rate_sel  = ang ? it_gy : it_gx;
    acc_sel   = ang ? acc_r : acc_p;
    vsum      = (MP_W+1)'(m1) + (MP_W+1)'(mul_p) + ROUND;
    vsh       = vsum >>> 31;
    if (vsh > SAT_HI) begin
      ang_new = ANG_W'(SAT_HI);
    end else if (vsh < SAT_LO) begin
      ang_new = ANG_W'(SAT_LO);
    end else begin
      ang_new = vsh[ANG_W-1:0];
    end
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      cord_start <= 1'b0;
      mul_start  <= 1'b0;
      for (int i = 0; i < SENSORS; i++) begin
        calib_sum_x[i] <= '0;
        calib_sum_y[i] <= '0;
        calib_sum_z[i] <= '0;
        calib_count[i] <= '0;
        offset_x[i]    <= '0;
        offset_y[i]    <= '0;
        offset_z[i]    <= '0;
        pitch_store[i] <= '0;
        roll_store[i]  <= '0;
      end
    end else begin
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      cord_start <= 1'b0;
      mul_start  <= 1'b0;
      // S_OUT reloads the slot itself whenever it is taken
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            it_type <= s_tuser[0];
            it_sid  <= s_tuser[1];
            it_ok   <= s_tuser[2];
            it_ax   <= s_tdata[15:0];
            it_ay   <= s_tdata[31:16];
            it_az   <= s_tdata[47:32];
            it_gx   <= s_tdata[63:48];
            it_gy   <= s_tdata[79:64];
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_p <= '0;
          res_r <= '0;
          if (!s_ok) begin
            // sensor out of range: report failure, touch nothing
            res_status <= ST_FAIL;
            state      <= S_OUT;
          end else if (!it_type) begin
            if (it_ok) begin
              calib_sum_x[sidx] <= sum_x_n;
              calib_sum_y[sidx] <= sum_y_n;
              calib_sum_z[sidx] <= sum_z_n;
            end
            calib_count[sidx] <= cnt_new;
            res_status <= it_ok ? ST_CAL_TAKEN : ST_FAIL;
            if (cnt_new >= CNT_W'(CALIB_SAMPLES)) begin
              res_status <= ST_CAL_DONE;
              axis       <= 2'd0;
              state      <= S_CAL_START;
            end else begin
              state <= S_OUT;
            end
          end else if (!it_ok) begin
            // failed measurement: hand back the held angles
            res_status <= ST_FAIL;
            res_p      <= pitch_store[sidx];
            res_r      <= roll_store[sidx];
            state      <= S_OUT;
          end else begin
            cx    <= it_ax - offset_x[sidx];
            cy    <= it_ay - offset_y[sidx];
            cz    <= it_az - offset_z[sidx];
            state <= S_SQ1;
          end
        end
        S_CAL_START: begin
          case (axis)
            2'd0:    div_din <= calib_sum_x[sidx];
            2'd1:    div_din <= calib_sum_y[sidx];
            default: div_din <= calib_sum_z[sidx];
          endcase
          div_start <= 1'b1;
          state     <= S_CAL_WAIT;
        end
        S_CAL_WAIT: begin
          if (div_done) begin
            case (axis)
              2'd0:    offset_x[sidx] <= div_q[AX_W-1:0];
              2'd1:    offset_y[sidx] <= div_q[AX_W-1:0];
              default: offset_z[sidx] <= div_q[AX_W-1:0] - AX_W'(gravity_lsb);
            endcase
            if (axis == 2'd2) begin
              calib_sum_x[sidx] <= '0;
              calib_sum_y[sidx] <= '0;
              calib_sum_z[sidx] <= '0;
              calib_count[sidx] <= '0;
              state             <= S_OUT;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_CAL_START;
            end
          end
        end
        S_SQ1: begin
          sq_y  <= cy * cy;
          state <= S_SQ2;
        end
        S_SQ2: begin
          sq_z  <= cz * cz;
          state <= S_SQ3;
        end
        S_SQ3: begin
          // magnitude and pitch CORDIC run side by side
          sqrt_din   <= SQ_W'(sq_y) + SQ_W'(sq_z);
          sqrt_start <= 1'b1;
          cord_y     <= CIN_W'(cy);
          cord_x     <= CIN_W'(cz);
          cord_start <= 1'b1;
          fsq        <= 1'b0;
          fcp        <= 1'b0;
          state      <= S_PWAIT;
        end
        S_PWAIT: begin
          fsq <= fsq | sqrt_done;
          fcp <= fcp | cord_done;
          if ((fsq | sqrt_done) && (fcp | cord_done)) begin
            state <= S_CROLL;
          end
        end
        S_CROLL: begin
          acc_p      <= cord_z;
          cord_y     <= -CIN_W'(cx);
          cord_x     <= $signed({1'b0, sqrt_root});
          cord_start <= 1'b1;
          state      <= S_RWAIT;
        end
        S_RWAIT: begin
          if (cord_done) begin
            acc_r <= cord_z;
            ang   <= 1'b0;
            state <= S_RG;
          end
        end
        S_RG: begin
          mul_a     <= MA_W'(gyro_step_gain);
          mul_b     <= MB_W'(rate_sel);
          mul_start <= 1'b1;
          state     <= S_RGW;
        end
        S_RGW: begin
          if (mul_done) begin
            mul_a     <= alpha_c;
            mul_b     <= MB_W'($signed({store_sel, 16'b0})) + $signed(mul_p[MB_W-1:0]);
            mul_start <= 1'b1;
            state     <= S_M1W;
          end
        end
        S_M1W: begin
          if (mul_done) begin
            m1        <= mul_p;
            mul_a     <= beta_c;
            mul_b     <= MB_W'($signed({acc_sel, 8'b0}));
            mul_start <= 1'b1;
            state     <= S_M2W;
          end
        end
        S_M2W: begin
          if (mul_done) begin
            if (!ang) begin
              pitch_store[sidx] <= ang_new;
              res_p             <= ang_new;
              ang               <= 1'b1;
              state             <= S_RG;
            end else begin
              roll_store[sidx] <= ang_new;
              res_r            <= ang_new;
              res_status       <= ST_ANGLES;
              state            <= S_OUT;
            end
          end
        end
        S_OUT: begin
          // hold until the output slot is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_r, res_p};
            m_tuser  <= {res_status, it_sid};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tilt filter: drives calibration and measurement
// samples, predicts every result transaction and compares field by field.
// ----------------------------------------------------------------------------
module testbench;
  import ctf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSENS = 2;
  localparam int NCAL  = 100;
  localparam int STEPS = 16;
  localparam longint CYCLE_LIMIT = 4000000;

  localparam logic [3:0] ADDR_ALPHA   = 4'h0;
  localparam logic [3:0] ADDR_GAIN    = 4'h4;
  localparam logic [3:0] ADDR_GRAVITY = 4'h8;

  localparam logic REQ_CAL  = 1'b0;
  localparam logic REQ_MEAS = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  imu_tilt_complementary_filter dut (.*);

  always #4 clk = ~clk;

  // Result of one sample as the block should report it.
  typedef struct packed {
    logic             sensor;
    status_t          status;
    logic [ANG_W-1:0] pitch;
    logic [ANG_W-1:0] roll;
  } tilt_result_t;

  tilt_result_t expected_tilt[$];

  // Predictor state mirrors the block's registers and per-sensor stores.
  logic [15:0]       alpha_q, gain_q;
  logic [14:0]       gravity_q;
  longint            sum_x[NSENS], sum_y[NSENS], sum_z[NSENS];
  int unsigned       attempts[NSENS];
  longint            off_x[NSENS], off_y[NSENS], off_z[NSENS];
  longint            pitch_q[NSENS], roll_q[NSENS];

  int  errors = 0;
  int  results_seen = 0;
  int  cal_rounds = 0;
  longint cycles = 0;
  bit  idle_in = 1'b1;      // random gaps on the sender side
  bit  idle_out = 1'b1;     // random stalls on the receiver side
  int  hold_off = 0;        // long receiver hold-off, counted in cycles

  function automatic longint wrap(longint v, int w);
    longint m;
    m = (longint'(1) << w) - 1;
    v = v & m;
    if (v >>> (w - 1)) return v - m - 1;
    return v;
  endfunction

  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint sq_root(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint arctan_step(int i);
    longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                      14668, 7334, 3667, 1833, 917, 458, 229, 115,
                      57, 29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  // Vectoring arctangent in 1/65536 degree.
  function automatic longint vector_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 16777216;
    y = y * 16777216;
    if (x < 0) begin
      if (y >= 0) begin
        z = 90 * 65536; t = x; x = y; y = -t;
      end else begin
        z = -90 * 65536; t = x; x = -y; y = t;
      end
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_step(i);
      end else begin
        x -= dx; y += dy; z -= arctan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint fuse_angle(longint stored, longint rate, longint acc);
    longint a, g, v;
    a = (alpha_q > 16'd32768) ? 32768 : longint'(alpha_q);
    g = stored * 65536 + rate * longint'(gain_q);
    v = shr_floor(a * g + (32768 - a) * acc * 256 + (longint'(1) << 30), 31);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  // Advance predictor state by one sample and queue the expected result.
  function automatic void predict_tilt(logic kind, logic sid, logic ok,
                                       logic [15:0] ax, ay, az, gx, gy);
    tilt_result_t r;
    longint cx, cy, cz, mag, p, q;
    int s;
    s = sid;
    r.sensor = sid;
    r.pitch = '0;
    r.roll = '0;
    if (s >= NSENS) begin
      r.status = ST_FAIL;
    end else if (kind == REQ_CAL) begin
      if (ok) begin
        sum_x[s] = wrap(sum_x[s] + longint'($signed(ax)), 24);
        sum_y[s] = wrap(sum_y[s] + longint'($signed(ay)), 24);
        sum_z[s] = wrap(sum_z[s] + longint'($signed(az)), 24);
      end
      attempts[s] = (attempts[s] + 1) & 7'h7f;
      r.status = ok ? ST_CAL_TAKEN : ST_FAIL;
      if (attempts[s] >= NCAL) begin
        off_x[s] = wrap(sum_x[s] / NCAL, 16);
        off_y[s] = wrap(sum_y[s] / NCAL, 16);
        off_z[s] = wrap(sum_z[s] / NCAL - longint'(gravity_q), 16);
        sum_x[s] = 0; sum_y[s] = 0; sum_z[s] = 0;
        attempts[s] = 0;
        r.status = ST_CAL_DONE;
        cal_rounds++;
      end
    end else if (!ok) begin
      r.status = ST_FAIL;
      r.pitch = pitch_q[s][ANG_W-1:0];
      r.roll = roll_q[s][ANG_W-1:0];
    end else begin
      cx = wrap(longint'($signed(ax)) - off_x[s], 16);
      cy = wrap(longint'($signed(ay)) - off_y[s], 16);
      cz = wrap(longint'($signed(az)) - off_z[s], 16);
      mag = sq_root(cy * cy + cz * cz);
      p = fuse_angle(pitch_q[s], longint'($signed(gx)), vector_angle(cy, cz));
      q = fuse_angle(roll_q[s], longint'($signed(gy)), vector_angle(-cx, mag));
      pitch_q[s] = p;
      roll_q[s] = q;
      r.status = ST_ANGLES;
      r.pitch = p[ANG_W-1:0];
      r.roll = q[ANG_W-1:0];
    end
    expected_tilt.push_back(r);
  endfunction

  // Send one sample transaction; predict it at acceptance. Valid stays up
  // afterwards until the next gap or drain, the block is busy meanwhile.
  task automatic send_sample(logic kind, logic sid, logic ok,
                             logic [15:0] ax, ay, az, gx, gy);
    int gap;
    if (idle_in && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {gy, gx, az, ay, ax};
    s_tuser  <= {ok, sid, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_tilt(kind, sid, ok, ax, ay, az, gx, gy);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_tilt.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Write one register over APB: setup then access.
  task automatic write_reg(logic [3:0] addr, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      ADDR_ALPHA:   alpha_q = value[15:0];
      ADDR_GAIN:    gain_q = value[15:0];
      default:      gravity_q = value[14:0];
    endcase
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(0);
      default: return 16'($urandom);
    endcase
  endfunction

  // Near-level reading around an arbitrary bias.
  function automatic logic [15:0] near(int center, int spread);
    return 16'(center + $urandom_range(0, 2 * spread) - spread);
  endfunction

  task automatic run_calibration(logic sid, int bias_x, int bias_y, int bias_z,
                                 int fail_pct);
    for (int i = 0; i < NCAL; i++)
      send_sample(REQ_CAL, sid, $urandom_range(0, 99) >= fail_pct,
                  near(bias_x, 300), near(bias_y, 300), near(bias_z, 300),
                  16'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    logic [15:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    // Fields at their extremes, both operands zero, negative x with zero y.
    send_sample(REQ_MEAS, 1'b0, 1'b1, 0, 0, 0, 0, 0);
    send_sample(REQ_MEAS, 1'b0, 1'b1, 0, 0, 16'h8000, 0, 0);
    send_sample(REQ_MEAS, 1'b1, 1'b1, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
    send_sample(REQ_MEAS, 1'b1, 1'b1, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
    for (int i = 0; i < 4; i++)
      send_sample(REQ_MEAS, i[0], 1'b1, ext[i], ext[3-i], ext[(i+1)%4], ext[i], ext[3-i]);
    send_sample(REQ_MEAS, 1'b0, 1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_sample(REQ_CAL, 1'b1, 1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0);
    send_sample(REQ_CAL, 1'b1, 1'b1, 16'h8000, 16'h8000, 16'h8000, 0, 0);
    send_sample(REQ_CAL, 1'b0, 1'b1, 16'hffff, 16'h0001, 16'h4000, 0, 0);
    // Saturation: pile up a large gyro rate with full gyro weight.
    wait_drained();
    write_reg(ADDR_ALPHA, 32'd40000);   // above one, acts as one
    write_reg(ADDR_GAIN, 32'hffff);
    for (int i = 0; i < 8; i++)
      send_sample(REQ_MEAS, 1'b0, 1'b1, 0, 0, 16'h4000, 16'h7fff, 16'h8000);
    send_sample(REQ_MEAS, 1'b0, 1'b0, 0, 0, 0, 0, 0);
    wait_drained();
    write_reg(ADDR_ALPHA, 32'd32113);
    write_reg(ADDR_GAIN, 32'd6404);
  endtask

  task automatic test_calibration();
    wait_drained();
    write_reg(ADDR_GRAVITY, 32'd0);
    run_calibration(1'b0, 500, -700, 16384, 10);
    wait_drained();
    write_reg(ADDR_GRAVITY, 32'h7fff);
    run_calibration(1'b1, -32000, 32000, -100, 30);
    wait_drained();
    write_reg(ADDR_GRAVITY, 32'd16384);
  endtask

  task automatic test_random_mix(int count);
    logic kind;
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(0, 9) < 3) ? REQ_CAL : REQ_MEAS;
      if ($urandom_range(0, 4) == 0)
        send_sample(kind, 1'($urandom), 1'($urandom), rand_word(), rand_word(),
                    rand_word(), rand_word(), rand_word());
      else
        send_sample(kind, 1'($urandom), $urandom_range(0, 15) != 0,
                    near(200, 2000), near(-300, 2000), near(16384, 3000),
                    near(0, 4000), near(0, 4000));
    end
  endtask

  task automatic test_config_sweep();
    logic [31:0] alphas[4] = '{32'd0, 32'd32768, 32'd16384, 32'd65535};
    logic [31:0] gains[4]  = '{32'd0, 32'd65535, 32'd1000, 32'd6404};
    for (int k = 0; k < 4; k++) begin
      wait_drained();
      write_reg(ADDR_ALPHA, alphas[k]);
      write_reg(ADDR_GAIN, gains[k]);
      write_reg(ADDR_GRAVITY, 32'($urandom_range(0, 32767)));
      test_random_mix(150);
    end
  endtask

  // Hold the receiver off long enough for the block to fill up.
  task automatic test_backpressure();
    wait_drained();
    @(negedge clk);
    hold_off = 300;
    @(posedge clk);
    test_random_mix(6);
  endtask

  // Receiver: random stall bursts, plus the long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else if (idle_out && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      hold_off <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare every accepted result transaction with the oldest expectation.
  always @(posedge clk) begin
    tilt_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_tilt.size() == 0) begin
        $display("%0t: unexpected result user=%h data=%h", $realtime, m_tuser, m_tdata);
        errors++;
      end else begin
        e = expected_tilt.pop_front();
        if (m_tuser[0] !== e.sensor) begin
          $display("%0t: sensor expected %0d actual %0d", $realtime, e.sensor, m_tuser[0]);
          errors++;
        end
        if (m_tuser[2:1] !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, e.status, m_tuser[2:1]);
          errors++;
        end
        if (m_tdata[23:0] !== e.pitch) begin
          $display("%0t: pitch expected %h actual %h", $realtime, e.pitch, m_tdata[23:0]);
          errors++;
        end
        if (m_tdata[47:24] !== e.roll) begin
          $display("%0t: roll expected %h actual %h", $realtime, e.roll, m_tdata[47:24]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_tilt.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    alpha_q = 16'd32113;
    gain_q = 16'd6404;
    gravity_q = 15'd16384;
    for (int s = 0; s < NSENS; s++) begin
      sum_x[s] = 0; sum_y[s] = 0; sum_z[s] = 0; attempts[s] = 0;
      off_x[s] = 0; off_y[s] = 0; off_z[s] = 0; pitch_q[s] = 0; roll_q[s] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_calibration();
    test_backpressure();
    test_random_mix(520);
    test_config_sweep();
    // Last stretch: no idling on either side.
    idle_in = 1'b0;
    idle_out = 1'b0;
    test_random_mix(200);
    wait_drained();
    $display("covered %0d results, %0d calibration rounds, register sweeps and back-pressure",
             results_seen, cal_rounds);
    if (errors == 0 && expected_tilt.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
